// ===== hw/rtl/prrts_pkg.sv =====
package prrts_pkg;

    // fixed field widths of the item channels
    localparam int KIND_W     = 2;
    localparam int PRIO_REQ_W = 8;
    localparam int TICK_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int TASK_ID_W  = 3;
    localparam int IN_W       = 40;
    localparam int OUT_W      = 40;

    // item kinds carried on s_tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_CREATE = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_DELAY  = 2'd2,
        KIND_YIELD  = 2'd3
    } kind_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_BAD_PRIO = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_PUSH = 2'd2
    } fsm_t;

    // per-slot sleep state held in the slot memory
    typedef struct packed {
        logic              blocked;
        logic [TICK_W-1:0] wake;
    } slot_state_t;

endpackage

// ===== hw/rtl/priority_round_robin_task_scheduler_core.sv =====
// channel  direction  handshake          tdata (lsb first)                  tuser
// s_       in         s_tvalid/s_tready  priority_req[7:0] delay_ticks[39:8] kind[1:0]
// m_       out        m_tvalid/m_tready  status[1:0] running_task[4:2]      -
//                                        created_index[7:5] tick_now[39:8]
//
// create, and delay while idle runs, go from accept through ST_PUSH to the output register.
// tick, yield and delay pass through ST_SCAN and ST_PUSH to the output register: the
// slot memories are read one slot a cycle over tasks_in_use - 1 slots, each read registered.
// one item is in work at a time; a new item is taken while a result waits at m_,
// and its own result then holds in the last cycle until m_ frees up.
// aresetn is synchronous; the slot memories need no clearing, only slots below
// tasks_in_use are read and each is written when it is created.
module priority_round_robin_task_scheduler_core
    import prrts_pkg::*;
#(
    parameter int MAX_TASKS       = 8,
    parameter int LOWEST_PRIORITY = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // priority_req[7:0], delay_ticks[39:8]
    input  logic [KIND_W-1:0] s_tuser,  // kind[1:0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status[1:0], running_task[4:2],
                                        // created_index[7:5], tick_now[39:8]
);

    localparam int IDX_W  = $clog2(MAX_TASKS);
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int PRIO_W = $clog2(LOWEST_PRIORITY + 2);

    // round-robin successor of a slot, skipping the idle slot
    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] k,
                                                   input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] kp;
        kp = CNT_W'(k) + CNT_W'(1);
        if (kp >= n) begin
            return IDX_W'(1);
        end
        return kp[IDX_W-1:0];
    endfunction

    fsm_t                  state_reg, state_next;
    logic [CNT_W-1:0]      in_use_reg, in_use_next;
    logic [IDX_W-1:0]      run_idx_reg, run_idx_next;
    logic [TICK_W-1:0]     tick_reg, tick_next;
    status_t               status_reg, status_next;
    logic [TASK_ID_W-1:0]  created_reg, created_next;
    logic                  scan_tick_reg, scan_tick_next;
    logic [IDX_W-1:0]      ptr_reg, ptr_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]      rd_addr_reg, rd_addr_next;
    logic [PRIO_W-1:0]     best_reg, best_next;
    logic [IDX_W-1:0]      pick_reg, pick_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]      m_tdata_reg, m_tdata_next;

    // slot memories and their ports
    slot_state_t           state_mem [MAX_TASKS];
    logic [PRIO_W-1:0]     prio_mem  [MAX_TASKS];
    slot_state_t           rd_state_reg;
    logic [PRIO_W-1:0]     rd_prio_reg;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  st_we;
    logic [IDX_W-1:0]      st_waddr;
    slot_state_t           st_wdata;
    logic                  pr_we;
    logic [IDX_W-1:0]      pr_waddr;
    logic [PRIO_W-1:0]     pr_wdata;

    kind_t                 kind;
    logic [PRIO_REQ_W-1:0] prio_req;
    logic [TICK_W-1:0]     delay_ticks;
    logic                  accept;
    logic                  out_free;
    logic                  scan_done;
    logic [TICK_W-1:0]     wake_diff;
    logic                  woke;
    logic                  slot_ready;

    assign kind        = kind_t'(s_tuser);
    assign prio_req    = s_tdata[PRIO_REQ_W-1:0];
    assign delay_ticks = s_tdata[PRIO_REQ_W +: TICK_W];
    assign accept      = s_tvalid && s_tready;
    assign out_free    = !m_tvalid_reg || m_tready;
    assign scan_done   = (rem_reg == '0) && !rd_vld_reg;

    // deadline test on the slot read last cycle
    assign wake_diff  = tick_reg - rd_state_reg.wake;
    assign woke       = scan_tick_reg && rd_state_reg.blocked &&
                        (rd_state_reg.wake != '0) && !wake_diff[TICK_W-1];
    assign slot_ready = !rd_state_reg.blocked || woke;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (kind == KIND_CREATE ||
                        (kind == KIND_DELAY && run_idx_reg == '0)) begin
                        state_next = ST_PUSH;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory ports
    always_comb begin
        s_tready       = (state_reg == ST_IDLE);
        in_use_next    = in_use_reg;
        run_idx_next   = run_idx_reg;
        tick_next      = tick_reg;
        status_next    = status_reg;
        created_next   = created_reg;
        scan_tick_next = scan_tick_reg;
        ptr_next       = ptr_reg;
        rem_next       = rem_reg;
        rd_vld_next    = 1'b0;
        rd_addr_next   = rd_addr_reg;
        best_next      = best_reg;
        pick_next      = pick_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg;
        st_we          = 1'b0;
        st_waddr       = run_idx_reg;
        st_wdata       = '0;
        pr_we          = 1'b0;
        pr_waddr       = in_use_reg[IDX_W-1:0];
        pr_wdata       = PRIO_W'(prio_req);
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    status_next    = STATUS_OK;
                    created_next   = '0;
                    scan_tick_next = (kind == KIND_TICK);
                    ptr_next       = next_slot(run_idx_reg, in_use_reg);
                    rem_next       = in_use_reg - CNT_W'(1);
                    best_next      = PRIO_W'(LOWEST_PRIORITY + 1);
                    pick_next      = '0;
                    case (kind)
                        KIND_CREATE: begin
                            if (in_use_reg >= CNT_W'(MAX_TASKS)) begin
                                status_next = STATUS_FULL;
                            end else if (prio_req > PRIO_REQ_W'(LOWEST_PRIORITY)) begin
                                status_next = STATUS_BAD_PRIO;
                            end else begin
                                pr_we        = 1'b1;
                                st_we        = 1'b1;
                                st_waddr     = in_use_reg[IDX_W-1:0];
                                created_next = TASK_ID_W'(in_use_reg);
                                in_use_next  = in_use_reg + CNT_W'(1);
                            end
                        end
                        KIND_TICK: begin
                            tick_next = tick_reg + TICK_W'(1);
                        end
                        KIND_DELAY: begin
                            if (run_idx_reg != '0) begin
                                st_we            = 1'b1;
                                st_wdata.blocked = 1'b1;
                                st_wdata.wake    = tick_reg + delay_ticks;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // issue the next slot read
                if (rem_reg != '0) begin
                    rd_en        = 1'b1;
                    rd_vld_next  = 1'b1;
                    rd_addr_next = ptr_reg;
                    ptr_next     = next_slot(ptr_reg, in_use_reg);
                    rem_next     = rem_reg - CNT_W'(1);
                end
                // wake and compare the slot that came back
                if (rd_vld_reg) begin
                    if (woke) begin
                        st_we    = 1'b1;
                        st_waddr = rd_addr_reg;
                    end
                    if (slot_ready && rd_prio_reg < best_reg) begin
                        best_next = rd_prio_reg;
                        pick_next = rd_addr_reg;
                    end
                end
                if (scan_done) begin
                    run_idx_next = pick_reg;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {tick_reg, created_reg,
                                     TASK_ID_W'(run_idx_reg), status_reg};
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            in_use_reg   <= CNT_W'(1);
            run_idx_reg  <= '0;
            tick_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            rem_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            in_use_reg   <= in_use_next;
            run_idx_reg  <= run_idx_next;
            tick_reg     <= tick_next;
            rd_vld_reg   <= rd_vld_next;
            rem_reg      <= rem_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        status_reg    <= status_next;
        created_reg   <= created_next;
        scan_tick_reg <= scan_tick_next;
        ptr_reg       <= ptr_next;
        rd_addr_reg   <= rd_addr_next;
        best_reg      <= best_next;
        pick_reg      <= pick_next;
        m_tdata_reg   <= m_tdata_next;
    end

    // slot memories, one write and one registered read each
    always_ff @(posedge aclk) begin
        if (st_we) begin
            state_mem[st_waddr] <= st_wdata;
        end
        if (pr_we) begin
            prio_mem[pr_waddr] <= pr_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_state_reg <= state_mem[rd_addr];
            rd_prio_reg  <= prio_mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/prrts_checker.sv =====
module prrts_checker
    import prrts_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // reset leaves no result pending and the input open
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (s_tready && !m_tvalid))
        else $error("scheduler not idle after reset");

    // status never takes the unused code
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == STATUS_OK || m_tdata[1:0] == STATUS_FULL ||
                      m_tdata[1:0] == STATUS_BAD_PRIO))
        else $error("status code out of range");

    // a failed create hands out no slot
    a_failed_create: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] != STATUS_OK) |-> (m_tdata[7:5] == 3'd0))
        else $error("slot given on failed create");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

endmodule

bind priority_round_robin_task_scheduler_core prrts_checker u_prrts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
